// File: rtl/jkms_pkg.sv
// Shared types, widths and helpers for the join key multiplicity scan.
package jkms_pkg;

  localparam int KEY_W        = 32;
  localparam int POS_W        = 10;
  localparam int CNT_W        = 11;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_t;

  // Saturating count increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == COUNT_MAX) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

// File: rtl/jkms_if.sv
// Valid/ready channel interfaces for input items and result items.
interface jkms_in_if;
  import jkms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic                    first_of_batch;
  logic signed [KEY_W-1:0] key_value;
  logic                    from_first_table;
  logic [POS_W-1:0]        position;

  modport source (output valid, kind, first_of_batch, key_value, from_first_table, position,
                  input ready);
  modport sink   (input valid, kind, first_of_batch, key_value, from_first_table, position,
                  output ready);
endinterface

interface jkms_out_if;
  import jkms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        first_count;
  logic [CNT_W-1:0]        second_count;
  logic signed [KEY_W-1:0] item_key;
  logic                    item_from_first;
  logic [POS_W-1:0]        stored_at;
  status_t                 status;

  modport source (output valid, first_count, second_count, item_key, item_from_first,
                  stored_at, status, input ready);
  modport sink   (input valid, first_count, second_count, item_key, item_from_first,
                  stored_at, status, output ready);
endinterface

// File: rtl/join_key_multiplicity_scan.sv
// Top level of the join key multiplicity scan.
// Load items (kind 0) append one element of a key-sorted combined table and
// return the running per-table counts of the element's key group; the open
// group's counts live in registers and the element and group totals are
// written to memory in the accept cycle. Read items (kind 1) first read the
// element memory, then read the group-totals memory at the element's group,
// then register the result once the result register is free. A read past
// the loaded count answers with status 2; a load into a full buffer answers
// with status 1. A new item is taken while no read is in flight and the
// result register is free or being emptied. The memories need no clearing
// after reset.
module join_key_multiplicity_scan
  import jkms_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  jkms_in_if.sink     in_ch,
  jkms_out_if.source  out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;
  localparam int IW = KEY_W + 1 + AW;   // key, flag, group
  localparam int GW = 2 * CNT_W;        // first, second totals

  typedef enum logic [1:0] {S_IDLE, S_ITEM, S_GRP} state_t;

  state_t                  state_r;
  logic [CW-1:0]           ld_cnt_r;
  logic [AW-1:0]           grp_r;
  logic [KEY_W-1:0]        prev_key_r;
  logic [CNT_W-1:0]        cur_first_r;
  logic [CNT_W-1:0]        cur_second_r;
  logic [POS_W-1:0]        rd_pos_r;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [CNT_W-1:0]        out_first_r;
  logic [CNT_W-1:0]        out_second_r;
  logic [KEY_W-1:0]        out_key_r;
  logic                    out_flag_r;
  logic [POS_W-1:0]        out_pos_r;
  status_t                 out_status_r;

  logic                    out_free;
  logic                    in_take;
  logic                    ld_take;
  logic                    rd_take;
  logic [CW-1:0]           base_cnt;
  logic                    full;
  logic                    new_grp;
  logic [AW-1:0]           grp_nxt;
  logic [CNT_W-1:0]        first_base;
  logic [CNT_W-1:0]        second_base;
  logic [CNT_W-1:0]        first_nxt;
  logic [CNT_W-1:0]        second_nxt;
  logic                    rd_hit;
  logic                    ld_we;

  logic [IW-1:0]           item_rdata;
  logic [GW-1:0]           grp_rdata;
  logic [AW-1:0]           item_grp;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_take = in_ch.valid && in_ch.ready;
  assign ld_take = in_take && (in_ch.kind == KIND_LOAD);
  assign rd_take = in_take && (in_ch.kind == KIND_READ);

  // Load path: group boundary and running counts
  always_comb begin
    base_cnt    = in_ch.first_of_batch ? '0 : ld_cnt_r;
    full        = !in_ch.first_of_batch && (ld_cnt_r == CW'(CAPACITY));
    new_grp     = (base_cnt == '0) || (in_ch.key_value != prev_key_r);
    if (base_cnt == '0) begin
      grp_nxt = '0;
    end else if (new_grp) begin
      grp_nxt = grp_r + AW'(1);
    end else begin
      grp_nxt = grp_r;
    end
    first_base  = new_grp ? '0 : cur_first_r;
    second_base = new_grp ? '0 : cur_second_r;
    first_nxt   = in_ch.from_first_table ? sat_inc(first_base) : first_base;
    second_nxt  = in_ch.from_first_table ? second_base : sat_inc(second_base);
  end

  assign ld_we  = ld_take && !full;
  assign rd_hit = WW'(in_ch.position) < WW'(ld_cnt_r);

  // result register loads on a load, a missed read or a finished read
  assign out_valid_nxt = ld_take || (rd_take && !rd_hit) ||
                         ((state_r == S_GRP) && out_free) ||
                         (out_valid_r && !out_ch.ready);

  jkms_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_item_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (AW'(base_cnt)),
    .wdata ({in_ch.key_value, in_ch.from_first_table, grp_nxt}),
    .re    (rd_take && rd_hit),
    .raddr (AW'(in_ch.position)),
    .rdata (item_rdata)
  );

  assign item_grp = item_rdata[AW-1:0];

  jkms_ram #(.WIDTH(GW), .DEPTH(CAPACITY)) u_grp_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (grp_nxt),
    .wdata ({first_nxt, second_nxt}),
    .re    (state_r == S_ITEM),
    .raddr (item_grp),
    .rdata (grp_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ld_cnt_r     <= '0;
      grp_r        <= '0;
      prev_key_r   <= '0;
      cur_first_r  <= '0;
      cur_second_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (ld_take) begin
            if (full) begin
              out_first_r  <= '0;
              out_second_r <= '0;
              out_key_r    <= '0;
              out_flag_r   <= 1'b0;
              out_pos_r    <= '0;
              out_status_r <= ST_FULL;
            end else begin
              ld_cnt_r     <= base_cnt + CW'(1);
              grp_r        <= grp_nxt;
              prev_key_r   <= in_ch.key_value;
              cur_first_r  <= first_nxt;
              cur_second_r <= second_nxt;
              out_first_r  <= first_nxt;
              out_second_r <= second_nxt;
              out_key_r    <= in_ch.key_value;
              out_flag_r   <= in_ch.from_first_table;
              out_pos_r    <= POS_W'(base_cnt);
              out_status_r <= ST_OK;
            end
          end else if (rd_take) begin
            rd_pos_r <= in_ch.position;
            if (rd_hit) begin
              state_r <= S_ITEM;
            end else begin
              out_first_r  <= '0;
              out_second_r <= '0;
              out_key_r    <= '0;
              out_flag_r   <= 1'b0;
              out_pos_r    <= in_ch.position;
              out_status_r <= ST_NOT_LOADED;
            end
          end
        end
        S_ITEM: begin
          state_r <= S_GRP;
        end
        S_GRP: begin
          // both RAM outputs hold until the result register frees up
          if (out_free) begin
            state_r      <= S_IDLE;
            out_first_r  <= grp_rdata[GW-1:CNT_W];
            out_second_r <= grp_rdata[CNT_W-1:0];
            out_key_r    <= item_rdata[IW-1:AW+1];
            out_flag_r   <= item_rdata[AW];
            out_pos_r    <= rd_pos_r;
            out_status_r <= ST_OK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.first_count     = out_first_r;
  assign out_ch.second_count    = out_second_r;
  assign out_ch.item_key        = out_key_r;
  assign out_ch.item_from_first = out_flag_r;
  assign out_ch.stored_at       = out_pos_r;
  assign out_ch.status          = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(ld_cnt_r) <= WW'(CAPACITY))
    else $error("loaded count above capacity");

  a_grp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_cnt_r != '0) |-> (CW'(grp_r) < ld_cnt_r))
    else $error("group index not below loaded count");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    ld_take |=> out_valid_r && (out_status_r == ST_OK || out_status_r == ST_FULL))
    else $error("load item without load result");

  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_take && rd_hit) |=> (state_r == S_ITEM) ##1 (state_r == S_GRP))
    else $error("read item skipped memory stages");

endmodule

// File: rtl/jkms_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module jkms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
